/* rtl/spwh_pkg.sv */
package spwh_pkg;

    // Default widths
    localparam int DEF_POS_BITS   = 16;
    localparam int DEF_TIMER_BITS = 16;

    // Fixed field widths
    localparam int CMD_BITS   = 3;
    localparam int VALUE_BITS = 16;
    localparam int CFG_BITS   = 16;
    localparam int APB_AW     = 4;
    localparam int APB_DW     = 32;

    // Configuration reset values
    localparam logic [CFG_BITS-1:0]        CFG_HALF_RST = 16'd1000;
    localparam logic signed [CFG_BITS-1:0] CFG_IMIN_RST = -16'sd100;
    localparam logic signed [CFG_BITS-1:0] CFG_IMAX_RST = 16'sd100;

    // Configuration register index (paddr[3:2])
    typedef enum logic [1:0] {
        REG_HALF = 2'd0,
        REG_IMIN = 2'd1,
        REG_IMAX = 2'd2
    } t_reg_idx;

    // Input word command codes
    typedef enum logic [CMD_BITS-1:0] {
        CMD_TICK      = 3'd0,
        CMD_MOVE_ABS  = 3'd1,
        CMD_MOVE_REL  = 3'd2,
        CMD_CALIBRATE = 3'd3,
        CMD_ENABLE    = 3'd4,
        CMD_DISABLE   = 3'd5
    } t_cmd_code;

    // Step pulse phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_HIGH = 2'd1,
        PH_LOW  = 2'd2
    } t_phase;

    // Homing phase
    typedef enum logic [1:0] {
        CAL_NONE  = 2'd0,
        CAL_LEFT  = 2'd1,
        CAL_RIGHT = 2'd2
    } t_cal;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_MUL   = 3'd1,
        ST_PREP  = 3'd2,
        ST_DIV   = 3'd3,
        ST_ADD   = 3'd4,
        ST_CLAMP = 3'd5,
        ST_POST  = 3'd6
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic mul;
        logic prep;
        logic div_step;
        logic add;
        logic clamp;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic move_go;
        logic div_last;
    } t_dp_sts;

endpackage

/* rtl/spwh_in_if.sv */
interface spwh_in_if import spwh_pkg::*;;
    logic                         valid;
    logic                         ready;
    logic [CMD_BITS-1:0]          command;
    logic signed [VALUE_BITS-1:0] value;
    logic                         left_limit_n;
    logic                         right_limit_n;

    modport source (
        output valid, command, value, left_limit_n, right_limit_n,
        input  ready
    );
    modport sink (
        input  valid, command, value, left_limit_n, right_limit_n,
        output ready
    );
endinterface

/* rtl/spwh_out_if.sv */
interface spwh_out_if import spwh_pkg::*; #(
    parameter int POS_BITS = DEF_POS_BITS
);
    logic                       valid;
    logic                       ready;
    logic                       step_pulse;
    logic                       step_dir;
    logic signed [POS_BITS-1:0] position;
    logic signed [POS_BITS-1:0] target;
    logic                       calibrating;
    logic                       calibrated;
    logic [POS_BITS-1:0]        calibration_steps;

    modport source (
        output valid, step_pulse, step_dir, position, target, calibrating,
               calibrated, calibration_steps,
        input  ready
    );
    modport sink (
        input  valid, step_pulse, step_dir, position, target, calibrating,
               calibrated, calibration_steps,
        output ready
    );
endinterface

/* rtl/spwh_ctrl.sv */
module spwh_ctrl import spwh_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_slot_free;

    assign w_accept    = (r_state == ST_IDLE) && i_in_valid;
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_sts.move_go ? ST_MUL : ST_POST;
                end
            end
            ST_MUL:   n_state = ST_PREP;
            ST_PREP:  n_state = ST_DIV;
            ST_DIV: begin
                if (i_sts.div_last) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD:   n_state = ST_CLAMP;
            ST_CLAMP: n_state = ST_POST;
            ST_POST: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath commands and handshake outputs
    always_comb begin
        o_cmd          = '0;
        o_in_ready     = (r_state == ST_IDLE);
        o_cmd.accept   = w_accept;
        o_cmd.mul      = (r_state == ST_MUL);
        o_cmd.prep     = (r_state == ST_PREP);
        o_cmd.div_step = (r_state == ST_DIV);
        o_cmd.add      = (r_state == ST_ADD);
        o_cmd.clamp    = (r_state == ST_CLAMP);
        o_cmd.load_out = (r_state == ST_POST) && w_slot_free;
    end

    // Output word valid: set on load, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/spwh_dp.sv */
module spwh_dp import spwh_pkg::*; #(
    parameter int POS_BITS   = DEF_POS_BITS,
    parameter int TIMER_BITS = DEF_TIMER_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_sts                      o_sts,
    input  logic [CMD_BITS-1:0]          i_command,
    input  logic signed [VALUE_BITS-1:0] i_value,
    input  logic                         i_left_limit_n,
    input  logic                         i_right_limit_n,
    input  logic [CFG_BITS-1:0]          i_half,
    input  logic signed [CFG_BITS-1:0]   i_imin,
    input  logic signed [CFG_BITS-1:0]   i_imax,
    output logic                         o_step_pulse,
    output logic                         o_step_dir,
    output logic signed [POS_BITS-1:0]   o_position,
    output logic signed [POS_BITS-1:0]   o_target,
    output logic                         o_calibrating,
    output logic                         o_calibrated,
    output logic [POS_BITS-1:0]          o_calibration_steps
);

    localparam int XW = VALUE_BITS + 1;          // input range difference
    localparam int YW = VALUE_BITS + 2;          // command value offset
    localparam int DW = POS_BITS + 1;            // bound span
    localparam int PW = YW + DW;                 // signed product
    localparam int NW = POS_BITS + 17;           // dividend magnitude
    localparam int SW = NW + 3;                  // final sum
    localparam int CW = $clog2(NW);
    localparam int HW = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

    // Architectural state
    logic signed [POS_BITS-1:0] r_pos,   n_pos;
    logic signed [POS_BITS-1:0] r_tgt,   n_tgt;
    logic signed [POS_BITS-1:0] r_lo,    n_lo;
    logic signed [POS_BITS-1:0] r_hi,    n_hi;
    logic                       r_en,    n_en;
    logic                       r_cald,  n_cald;
    t_phase                     r_phase, n_phase;
    logic [TIMER_BITS-1:0]      r_timer, n_timer;
    logic                       r_dir,   n_dir;
    t_cal                       r_calph, n_calph;
    logic [POS_BITS-1:0]        r_count, n_count;

    // Move arithmetic
    logic signed [VALUE_BITS-1:0] r_val;
    logic                         r_rel;
    logic signed [PW-1:0]         r_prod;
    logic                         r_neg;
    logic [NW-1:0]                r_quo;
    logic [XW-1:0]                r_rem;
    logic [XW-1:0]                r_dvs;
    logic [CW-1:0]                r_cnt;
    logic signed [SW-1:0]         r_sum;

    logic [HW-1:0]             w_half_ext;
    logic [HW-1:0]             w_tmr_max_ext;
    logic [TIMER_BITS-1:0]     w_half;
    logic signed [XW-1:0]      w_den;
    logic signed [YW-1:0]      w_xd;
    logic signed [DW-1:0]      w_od;
    logic [PW-1:0]             w_pabs;
    logic [XW-1:0]             w_dabs;
    logic [XW:0]               w_rsh;
    logic                      w_fit;
    logic signed [SW-1:0]      w_q;
    logic signed [SW-1:0]      w_om;
    logic signed [SW-1:0]      w_tadd;
    logic signed [SW-1:0]      w_lo_x;
    logic signed [SW-1:0]      w_hi_x;
    logic                      w_is_move;

    // Clamp the half period to the timer range
    assign w_half_ext    = HW'(i_half);
    assign w_tmr_max_ext = HW'({TIMER_BITS{1'b1}});
    assign w_half        = (w_half_ext > w_tmr_max_ext) ? TIMER_BITS'(w_tmr_max_ext)
                                                         : TIMER_BITS'(w_half_ext);

    // Range differences; relative moves offset the value by twice input_min
    assign w_den = {i_imax[CFG_BITS-1], i_imax} - {i_imin[CFG_BITS-1], i_imin};
    assign w_xd  = {{2{r_val[VALUE_BITS-1]}}, r_val}
                 - (r_rel ? {i_imin[CFG_BITS-1], i_imin, 1'b0}
                          : {{2{i_imin[CFG_BITS-1]}}, i_imin});
    assign w_od  = {r_hi[POS_BITS-1], r_hi} - {r_lo[POS_BITS-1], r_lo};

    // Start a move only when the input range is not empty
    assign w_is_move = (i_command == CMD_MOVE_ABS) || (i_command == CMD_MOVE_REL);
    assign o_sts.move_go  = w_is_move && (w_den != '0);
    assign o_sts.div_last = (r_cnt == CW'(NW - 1));

    // Magnitudes for the divider
    assign w_pabs = r_prod[PW-1] ? PW'(-r_prod) : PW'(r_prod);
    assign w_dabs = w_den[XW-1] ? XW'(-w_den) : XW'(w_den);

    // One restoring divide step
    assign w_rsh = {r_rem, r_quo[NW-1]};
    assign w_fit = (w_rsh >= {1'b0, r_dvs});

    // Signed quotient, offset and clamp operands
    assign w_q    = r_neg ? -$signed({{(SW-NW){1'b0}}, r_quo})
                          : $signed({{(SW-NW){1'b0}}, r_quo});
    assign w_lo_x = {{(SW-POS_BITS){r_lo[POS_BITS-1]}}, r_lo};
    assign w_hi_x = {{(SW-POS_BITS){r_hi[POS_BITS-1]}}, r_hi};
    assign w_om   = r_rel ? (w_lo_x <<< 1) : w_lo_x;
    assign w_tadd = r_rel ? {{(SW-POS_BITS){r_tgt[POS_BITS-1]}}, r_tgt} : '0;

    // Next architectural state
    always_comb begin
        t_phase                v_ph;
        logic [TIMER_BITS-1:0] v_tm;
        t_cal                  v_cal;
        logic                  v_start;
        logic                  v_sdir;
        logic [POS_BITS-1:0]   v_h;

        n_pos   = r_pos;
        n_tgt   = r_tgt;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_en    = r_en;
        n_cald  = r_cald;
        n_phase = r_phase;
        n_timer = r_timer;
        n_dir   = r_dir;
        n_calph = r_calph;
        n_count = r_count;
        v_ph    = r_phase;
        v_tm    = r_timer;
        v_cal   = r_calph;
        v_start = 1'b0;
        v_sdir  = 1'b0;
        v_h     = r_count >> 1;

        if (i_cmd.accept) begin
            case (t_cmd_code'(i_command))
                CMD_TICK: begin
                    if (r_phase != PH_IDLE) begin
                        // Advance the running pulse
                        if (v_ph == PH_HIGH) begin
                            if (v_tm >= w_half) begin
                                v_ph = PH_LOW;
                                v_tm = TIMER_BITS'(1);
                            end else begin
                                v_tm = v_tm + 1'b1;
                            end
                        end else if (v_tm < w_half) begin
                            v_tm = v_tm + 1'b1;
                        end
                        if (v_ph == PH_LOW && v_tm >= w_half) begin
                            v_ph = PH_IDLE;
                            v_tm = '0;
                            if (r_dir) begin
                                n_pos = r_pos + 1'b1;
                                if (r_calph == CAL_RIGHT && r_count != '1) begin
                                    n_count = r_count + 1'b1;
                                end
                            end else begin
                                n_pos = r_pos - 1'b1;
                            end
                        end
                        n_phase = v_ph;
                        n_timer = v_tm;
                    end else begin
                        // Homing left, then right
                        if (v_cal == CAL_LEFT) begin
                            if (r_en && i_left_limit_n) begin
                                v_start = 1'b1;
                                v_sdir  = 1'b0;
                            end else begin
                                v_cal = CAL_RIGHT;
                            end
                        end
                        if (!v_start && v_cal == CAL_RIGHT) begin
                            if (r_en && i_right_limit_n) begin
                                v_start = 1'b1;
                                v_sdir  = 1'b1;
                            end else begin
                                n_pos  = v_h;
                                n_hi   = v_h;
                                n_lo   = -v_h;
                                n_tgt  = '0;
                                n_cald = 1'b1;
                                v_cal  = CAL_NONE;
                            end
                        end else if (!v_start && r_en) begin
                            // Step toward the target unless blocked
                            if (r_tgt < r_pos) begin
                                if (i_left_limit_n) begin
                                    v_start = 1'b1;
                                    v_sdir  = 1'b0;
                                end
                            end else if (r_tgt > r_pos) begin
                                if (i_right_limit_n) begin
                                    v_start = 1'b1;
                                    v_sdir  = 1'b1;
                                end
                            end
                        end
                        n_calph = v_cal;
                        if (v_start) begin
                            n_phase = PH_HIGH;
                            n_timer = TIMER_BITS'(1);
                            n_dir   = v_sdir;
                        end
                    end
                end
                CMD_CALIBRATE: begin
                    n_calph = CAL_LEFT;
                    n_count = '0;
                end
                CMD_ENABLE:  n_en = 1'b1;
                CMD_DISABLE: n_en = 1'b0;
                default: ;
            endcase
        end

        // Clamp the new target to the travel bounds
        if (i_cmd.clamp) begin
            if (r_sum < w_lo_x) begin
                n_tgt = r_lo;
            end else if (r_sum > w_hi_x) begin
                n_tgt = r_hi;
            end else begin
                n_tgt = r_sum[POS_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_tgt   <= '0;
            r_lo    <= '0;
            r_hi    <= '0;
            r_en    <= 1'b0;
            r_cald  <= 1'b0;
            r_phase <= PH_IDLE;
            r_timer <= '0;
            r_dir   <= 1'b0;
            r_calph <= CAL_NONE;
            r_count <= '0;
        end else begin
            r_pos   <= n_pos;
            r_tgt   <= n_tgt;
            r_lo    <= n_lo;
            r_hi    <= n_hi;
            r_en    <= n_en;
            r_cald  <= n_cald;
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_dir   <= n_dir;
            r_calph <= n_calph;
            r_count <= n_count;
        end
    end

    // Move scaling: multiply, divide, offset
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_val <= i_value;
            r_rel <= (i_command == CMD_MOVE_REL);
        end
        if (i_cmd.mul) begin
            r_prod <= w_xd * w_od;
        end
        if (i_cmd.prep) begin
            r_neg <= r_prod[PW-1] ^ w_den[XW-1];
            r_quo <= w_pabs[NW-1:0];
            r_dvs <= w_dabs;
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[NW-2:0], w_fit};
            r_rem <= w_fit ? XW'(w_rsh - {1'b0, r_dvs}) : w_rsh[XW-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.add) begin
            r_sum <= w_q + w_om + w_tadd;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_step_pulse        <= (r_phase == PH_HIGH);
            o_step_dir          <= r_dir;
            o_position          <= r_pos;
            o_target            <= r_tgt;
            o_calibrating       <= (r_calph != CAL_NONE);
            o_calibrated        <= r_cald;
            o_calibration_steps <= r_count;
        end
    end

endmodule

/* rtl/stepper_positioner_with_homing_core.sv */
// Channel    Dir  Word fields
// i_cmd_ch   in   command, value, left_limit_n, right_limit_n
// o_res_ch   out  step_pulse, step_dir, position, target, calibrating,
//                 calibrated, calibration_steps
// APB        in   half_period_ticks @0x0, input_min @0x4, input_max @0x8
//
// Ticks, calibrate, enable and disable update the state at the accept edge;
// the result word loads from ST_POST once the output slot is free.
// Moves run ST_MUL, ST_PREP, ST_DIV, ST_ADD and ST_CLAMP before ST_POST; the
// bit-serial restoring divider in ST_DIV scales the command value.
// A new word is accepted while the previous result waits on o_res_ch.
// Reset is synchronous; all positions, bounds and flags clear to zero.
module stepper_positioner_with_homing_core import spwh_pkg::*; #(
    parameter int POS_BITS   = DEF_POS_BITS,
    parameter int TIMER_BITS = DEF_TIMER_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    spwh_in_if.sink           i_cmd_ch,
    spwh_out_if.source        o_res_ch,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [CFG_BITS-1:0]        r_half;
    logic signed [CFG_BITS-1:0] r_imin;
    logic signed [CFG_BITS-1:0] r_imax;
    logic                       w_wr;
    t_reg_idx                   w_idx;
    t_dp_cmd                    w_cmd;
    t_dp_sts                    w_sts;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= CFG_HALF_RST;
            r_imin <= CFG_IMIN_RST;
            r_imax <= CFG_IMAX_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_HALF: r_half <= pwdata[CFG_BITS-1:0];
                REG_IMIN: r_imin <= pwdata[CFG_BITS-1:0];
                REG_IMAX: r_imax <= pwdata[CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Configuration reads
    always_comb begin
        case (w_idx)
            REG_HALF: prdata = APB_DW'(r_half);
            REG_IMIN: prdata = APB_DW'(unsigned'(r_imin));
            REG_IMAX: prdata = APB_DW'(unsigned'(r_imax));
            default:  prdata = '0;
        endcase
    end

    spwh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd_ch.valid),
        .o_in_ready  (i_cmd_ch.ready),
        .o_out_valid (o_res_ch.valid),
        .i_out_ready (o_res_ch.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    spwh_dp #(
        .POS_BITS   (POS_BITS),
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_sts               (w_sts),
        .i_command           (i_cmd_ch.command),
        .i_value             (i_cmd_ch.value),
        .i_left_limit_n      (i_cmd_ch.left_limit_n),
        .i_right_limit_n     (i_cmd_ch.right_limit_n),
        .i_half              (r_half),
        .i_imin              (r_imin),
        .i_imax              (r_imax),
        .o_step_pulse        (o_res_ch.step_pulse),
        .o_step_dir          (o_res_ch.step_dir),
        .o_position          (o_res_ch.position),
        .o_target            (o_res_ch.target),
        .o_calibrating       (o_res_ch.calibrating),
        .o_calibrated        (o_res_ch.calibrated),
        .o_calibration_steps (o_res_ch.calibration_steps)
    );

endmodule

/* sim/tb.sv */
module tb import spwh_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int POS_BITS = DEF_POS_BITS;
    localparam int N_DIRECTED = 28;
    localparam int N_PHASES = 9;
    localparam int WORDS_PER_PHASE = 70;

    // Command codes with no function in the block
    localparam logic [CMD_BITS-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_RSVD7 = 3'd7;

    typedef struct packed {
        logic                       pulse;
        logic                       dir;
        logic signed [POS_BITS-1:0] pos;
        logic signed [POS_BITS-1:0] tgt;
        logic                       homing;
        logic                       homed;
        logic [POS_BITS-1:0]        steps;
    } t_status;

    typedef struct packed {
        logic [CMD_BITS-1:0]          cmd;
        logic signed [VALUE_BITS-1:0] val;
        logic                         lnl;
        logic                         rnl;
        logic                         typed;
        t_status                      res;
    } t_stim_row;

    localparam t_status ST_ZERO = '0;

    // Directed words: reset state, extremes, reserved codes, disable during
    // homing, homing restart, short homing run, then clamped moves
    localparam t_stim_row DIR_TAB [N_DIRECTED] = '{
        '{CMD_TICK,      16'sd0,      1'b1, 1'b1, 1'b1, ST_ZERO},
        '{CMD_RSVD7,     16'sh8000,   1'b0, 1'b0, 1'b1, ST_ZERO},
        '{CMD_MOVE_ABS,  16'sh7FFF,   1'b1, 1'b1, 1'b1, ST_ZERO},
        '{CMD_MOVE_REL,  16'sh8000,   1'b1, 1'b1, 1'b1, ST_ZERO},
        '{CMD_RSVD6,     16'sh5555,   1'b1, 1'b0, 1'b1, ST_ZERO},
        '{CMD_ENABLE,    16'sh2AAA,   1'b0, 1'b1, 1'b1, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b1, 1'b1, 1'b1, ST_ZERO},
        '{CMD_CALIBRATE, 16'sd0,      1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_DISABLE,   16'sd0,      1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_ENABLE,    16'sd0,      1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_CALIBRATE, 16'sd0,      1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b0, 1'b1, 1'b0, ST_ZERO},
        '{CMD_CALIBRATE, 16'sd0,      1'b0, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b0, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b0, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b0, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b0, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b0, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b0, 1'b0, 1'b0, ST_ZERO},
        '{CMD_MOVE_ABS,  16'sh8000,   1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_MOVE_ABS,  16'sh7FFF,   1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_MOVE_REL,  16'sd0,      1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_MOVE_ABS,  -16'sd100,   1'b1, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b0, 1'b1, 1'b0, ST_ZERO},
        '{CMD_TICK,      16'sd0,      1'b1, 1'b1, 1'b0, ST_ZERO}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    spwh_in_if cmd_ch ();
    spwh_out_if #(.POS_BITS(POS_BITS)) res_ch ();

    stepper_positioner_with_homing_core #(
        .POS_BITS   (POS_BITS),
        .TIMER_BITS (DEF_TIMER_BITS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_res_ch (res_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Register copies and positioner state mirrored from the block
    logic [CFG_BITS-1:0]        cfg_half;
    logic signed [CFG_BITS-1:0] cfg_imin;
    logic signed [CFG_BITS-1:0] cfg_imax;
    logic signed [POS_BITS-1:0] pos_q;
    logic signed [POS_BITS-1:0] tgt_q;
    logic signed [POS_BITS-1:0] lo_q;
    logic signed [POS_BITS-1:0] hi_q;
    logic                       drive_on;
    logic                       homed_q;
    t_phase                     pulse_ph;
    logic [DEF_TIMER_BITS-1:0]  pulse_tmr;
    logic                       pulse_dir;
    t_cal                       home_ph;
    logic [POS_BITS-1:0]        home_cnt;

    t_status pending_status [$];
    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int mismatches = 0;
    int words_checked = 0;
    int homings_done = 0;
    int max_home_cnt = 0;

    function automatic void check_field(string name, logic signed [63:0] exp_v,
                                        logic signed [63:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endfunction

    function automatic logic signed [POS_BITS-1:0] clamp_travel(longint x);
        if (x < longint'(lo_q)) return lo_q;
        if (x > longint'(hi_q)) return hi_q;
        return x[POS_BITS-1:0];
    endfunction

    // Map x from imin..imax onto omin..omax, truncating toward zero
    function automatic bit scale_value(longint x, longint imin, longint imax,
                                       longint omin, longint omax, output longint res);
        longint den;
        den = imax - imin;
        if (den == 0) return 1'b0;
        res = (x - imin) * (omax - omin) / den + omin;
        return 1'b1;
    endfunction

    function automatic void start_pulse(logic dir);
        pulse_dir = dir;
        pulse_ph = PH_HIGH;
        pulse_tmr = DEF_TIMER_BITS'(1);
    endfunction

    function automatic void advance_tick(logic lhit, logic rhit);
        logic [POS_BITS-1:0] half_cnt;
        // Run the pulse in flight to its end, nothing else on those ticks
        if (pulse_ph == PH_HIGH || pulse_ph == PH_LOW) begin
            if (pulse_ph == PH_HIGH) begin
                if (pulse_tmr >= cfg_half) begin
                    pulse_ph = PH_LOW;
                    pulse_tmr = DEF_TIMER_BITS'(1);
                end else begin
                    pulse_tmr++;
                end
            end else if (pulse_tmr < cfg_half) begin
                pulse_tmr++;
            end
            if (pulse_ph == PH_LOW && pulse_tmr >= cfg_half) begin
                pulse_ph = PH_IDLE;
                pulse_tmr = '0;
                if (pulse_dir) begin
                    pos_q = pos_q + 1'b1;
                    if (home_ph == CAL_RIGHT && home_cnt != '1) home_cnt++;
                end else begin
                    pos_q = pos_q - 1'b1;
                end
            end
            return;
        end
        pulse_ph = PH_IDLE;
        // Homing: seek left, then right while counting
        if (home_ph == CAL_LEFT) begin
            if (drive_on && !lhit) begin
                start_pulse(1'b0);
                return;
            end
            home_ph = CAL_RIGHT;
        end
        if (home_ph == CAL_RIGHT) begin
            if (drive_on && !rhit) begin
                start_pulse(1'b1);
                return;
            end
            half_cnt = home_cnt >> 1;
            pos_q = half_cnt;
            hi_q = half_cnt;
            lo_q = -$signed(half_cnt);
            tgt_q = '0;
            homed_q = 1'b1;
            home_ph = CAL_NONE;
            homings_done++;
            if (int'(home_cnt) > max_home_cnt) max_home_cnt = int'(home_cnt);
            return;
        end
        if (!drive_on) return;
        // Step toward the target unless that limit is active
        if (tgt_q < pos_q) begin
            if (!lhit) start_pulse(1'b0);
        end else if (tgt_q > pos_q) begin
            if (!rhit) start_pulse(1'b1);
        end
    endfunction

    function automatic t_status step_positioner(logic [CMD_BITS-1:0] cmd,
                                                logic signed [VALUE_BITS-1:0] val,
                                                logic lnl, logic rnl);
        longint mapped;
        t_status r;
        case (cmd)
            CMD_TICK: advance_tick(!lnl, !rnl);
            CMD_MOVE_ABS: begin
                if (scale_value(val, cfg_imin, cfg_imax, lo_q, hi_q, mapped))
                    tgt_q = clamp_travel(mapped);
            end
            CMD_MOVE_REL: begin
                if (scale_value(val, 2 * longint'(cfg_imin), 2 * longint'(cfg_imax),
                                2 * longint'(lo_q), 2 * longint'(hi_q), mapped))
                    tgt_q = clamp_travel(longint'(tgt_q) + mapped);
            end
            CMD_CALIBRATE: begin
                home_ph = CAL_LEFT;
                home_cnt = '0;
            end
            CMD_ENABLE: drive_on = 1'b1;
            CMD_DISABLE: drive_on = 1'b0;
            default: ;
        endcase
        r.pulse = (pulse_ph == PH_HIGH);
        r.dir = pulse_dir;
        r.pos = pos_q;
        r.tgt = tgt_q;
        r.homing = (home_ph != CAL_NONE);
        r.homed = homed_q;
        r.steps = home_cnt;
        return r;
    endfunction

    // Send one word with random idle gaps, predict it once accepted
    task automatic send_word(logic [CMD_BITS-1:0] cmd, logic signed [VALUE_BITS-1:0] val,
                             logic lnl, logic rnl, logic typed, t_status typed_res);
        t_status pred;
        if ($urandom_range(99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < src_idle_pct);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.value <= val;
        cmd_ch.left_limit_n <= lnl;
        cmd_ch.right_limit_n <= rnl;
        do @(posedge i_clk); while (!cmd_ch.ready);
        pred = step_positioner(cmd, val, lnl, rnl);
        pending_status.push_back(typed ? typed_res : pred);
    endtask

    // Hold off the sender until every expected word is back
    task automatic drain_results();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_status.size() != 0);
    endtask

    task automatic apb_xfer(t_reg_idx idx, logic wr, logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
    endtask

    task automatic apb_release();
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_BITS-1:0] data);
        logic [APB_DW-1:0] unused;
        apb_xfer(idx, 1'b1, {16'($urandom), data}, unused);
        case (idx)
            REG_HALF: cfg_half = data;
            REG_IMIN: cfg_imin = data;
            REG_IMAX: cfg_imax = data;
            default: ;
        endcase
    endtask

    // Mostly enabled homing and moves with random content, some noise
    task automatic run_random(int n);
        int sel;
        int span;
        logic [CMD_BITS-1:0] cmd;
        logic signed [VALUE_BITS-1:0] val;
        send_word(CMD_ENABLE, 16'($urandom), 1'b1, 1'b1, 1'b0, ST_ZERO);
        send_word(CMD_CALIBRATE, 16'($urandom), 1'b1, 1'b1, 1'b0, ST_ZERO);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(49) == 0) drain_results();
            sel = $urandom_range(99);
            if (sel < 62) cmd = CMD_TICK;
            else if (sel < 72) cmd = CMD_MOVE_ABS;
            else if (sel < 82) cmd = CMD_MOVE_REL;
            else if (sel < 85) cmd = CMD_CALIBRATE;
            else if (sel < 91) cmd = CMD_ENABLE;
            else if (sel < 95) cmd = CMD_DISABLE;
            else cmd = $urandom_range(1) ? CMD_RSVD7 : CMD_RSVD6;
            if ($urandom_range(1)) begin
                val = 16'($urandom);
            end else begin
                span = $urandom_range(400);
                val = 16'(span - 200);
            end
            send_word(cmd, val, $urandom_range(9) != 0, $urandom_range(9) != 0,
                      1'b0, ST_ZERO);
        end
    endtask

    // Check each returned word against the oldest prediction
    initial begin
        t_status got;
        t_status want;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                got = {res_ch.step_pulse, res_ch.step_dir, res_ch.position, res_ch.target,
                       res_ch.calibrating, res_ch.calibrated, res_ch.calibration_steps};
                if (pending_status.size() == 0) begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, expected none, got %h",
                             $time, got);
                end else begin
                    want = pending_status.pop_front();
                    words_checked++;
                    check_field("step_pulse", want.pulse, got.pulse);
                    check_field("step_dir", want.dir, got.dir);
                    check_field("position", want.pos, got.pos);
                    check_field("target", want.tgt, got.tgt);
                    check_field("calibrating", want.homing, got.homing);
                    check_field("calibrated", want.homed, got.homed);
                    check_field("calibration_steps", want.steps, got.steps);
                end
            end
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        logic [APB_DW-1:0] rd;
        logic [CFG_BITS-1:0] half_v;
        logic [CFG_BITS-1:0] imin_v;
        logic [CFG_BITS-1:0] imax_v;
        i_rst_n <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.command <= CMD_TICK;
        cmd_ch.value <= '0;
        cmd_ch.left_limit_n <= 1'b1;
        cmd_ch.right_limit_n <= 1'b1;
        cfg_half = CFG_HALF_RST;
        cfg_imin = CFG_IMIN_RST;
        cfg_imax = CFG_IMAX_RST;
        pos_q = '0;
        tgt_q = '0;
        lo_q = '0;
        hi_q = '0;
        drive_on = 1'b0;
        homed_q = 1'b0;
        pulse_ph = PH_IDLE;
        pulse_tmr = '0;
        pulse_dir = 1'b0;
        home_ph = CAL_NONE;
        home_cnt = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Registers come out of reset at their defaults
        apb_xfer(REG_HALF, 1'b0, '0, rd);
        check_field("half_period_ticks after reset", {48'd0, CFG_HALF_RST}, {48'd0, rd[15:0]});
        apb_xfer(REG_IMIN, 1'b0, '0, rd);
        check_field("input_min after reset", {48'd0, CFG_IMIN_RST}, {48'd0, rd[15:0]});
        apb_xfer(REG_IMAX, 1'b0, '0, rd);
        check_field("input_max after reset", {48'd0, CFG_IMAX_RST}, {48'd0, rd[15:0]});
        write_reg(REG_HALF, 16'd1);
        apb_release();

        // Directed table
        src_idle_pct = 36;
        snk_idle_pct = 63;
        for (int i = 0; i < N_DIRECTED; i++)
            send_word(DIR_TAB[i].cmd, DIR_TAB[i].val, DIR_TAB[i].lnl, DIR_TAB[i].rnl,
                      DIR_TAB[i].typed, DIR_TAB[i].res);

        // Random phases, one register setting each
        for (int p = 0; p < N_PHASES; p++) begin
            if (p == 3) begin
                src_idle_pct = 63;
                snk_idle_pct = 36;
            end else if (p == 6) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            drain_results();
            case (p)
                0: begin half_v = 16'd1; imin_v = -16'sd100; imax_v = 16'sd100; end
                1: begin half_v = 16'd2; imin_v = 16'sh8000; imax_v = 16'sh7FFF; end
                2: begin half_v = 16'd0; imin_v = 16'sd7; imax_v = 16'sd7; end
                3: begin half_v = 16'hFFFF; imin_v = 16'sh7FFF; imax_v = 16'sh8000; end
                4: begin
                    half_v = 16'($urandom_range(1, 4));
                    imin_v = 16'($urandom);
                    imax_v = 16'($urandom);
                end
                5: begin half_v = 16'd1; imin_v = -16'sd1000; imax_v = 16'sd1000; end
                6: begin half_v = 16'd1; imin_v = 16'($urandom); imax_v = 16'($urandom); end
                7: begin half_v = 16'd3; imin_v = 16'sh8000; imax_v = 16'sh7FFF; end
                default: begin half_v = 16'd1; imin_v = 16'sd0; imax_v = 16'sd50; end
            endcase
            write_reg(REG_HALF, half_v);
            write_reg(REG_IMIN, imin_v);
            write_reg(REG_IMAX, imax_v);
            apb_release();
            run_random(WORDS_PER_PHASE);
        end

        // Let the last words and any latecomers come out
        drain_results();
        repeat (60) @(posedge i_clk);
        $display("Covered %0d result words over %0d register settings and three idling modes.",
                 words_checked, N_PHASES + 1);
        $display("Homing finished %0d times, largest step count %0d.",
                 homings_done, max_home_cnt);
        if (mismatches == 0 && pending_status.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* stepper_positioner_with_homing_core.f */
rtl/spwh_pkg.sv
rtl/spwh_in_if.sv
rtl/spwh_out_if.sv
rtl/spwh_ctrl.sv
rtl/spwh_dp.sv
rtl/stepper_positioner_with_homing_core.sv
sim/tb.sv
